>>> design/sc2u_pkg.sv
// Shared types, constants and lookup functions for the screencode to UTF-8 encoder.
// No dependencies; sc2u_decode, sc2u_emit and the top module use this package.
`timescale 1ns / 1ps

package sc2u_pkg;

  localparam logic [7:0] ESC_BYTE     = 8'h1b;
  localparam logic [7:0] BRACKET_BYTE = 8'h5b;  // '['
  localparam logic [7:0] SGR_END_BYTE = 8'h6d;  // 'm'
  localparam logic [7:0] REV_ON_DIGIT = 8'h37;  // '7'
  localparam logic [7:0] REV_OFF_DIGIT = 8'h30; // '0'
  localparam logic [7:0] UNKNOWN_BYTE = 8'h3f;  // '?'

  localparam logic [3:0] ESC_LEN     = 4'd4;
  localparam logic [3:0] REV_EXTRA   = 4'd8;

  typedef enum logic [1:0] {
    ESC_POS_ESC     = 2'd0,
    ESC_POS_BRACKET = 2'd1,
    ESC_POS_DIGIT   = 2'd2,
    ESC_POS_END     = 2'd3
  } esc_pos_t;

  // Held transaction as seen by the decoder
  typedef struct packed {
    logic       upper;
    logic [7:0] code;
  } sc2u_key_t;

  // Decoded transaction: body bytes, body length (1..3) and reverse flag
  typedef struct packed {
    logic            rev;
    logic [1:0]      body_len;
    logic [2:0][7:0] body;
  } sc2u_item_t;

  typedef struct packed {
    logic        found;
    logic [15:0] point;
  } glyph_t;

  function automatic glyph_t glyph_lookup(input logic [6:0] code);
    glyph_t g;
    g.found = 1'b1;
    case (code)
      7'h40, 7'h43: g.point = 16'h2501;
      7'h60: g.point = 16'h00a0;
      7'h61: g.point = 16'h258c;
      7'h62: g.point = 16'h2584;
      7'h63: g.point = 16'h2594;
      7'h64: g.point = 16'h2581;
      7'h65: g.point = 16'h258e;
      7'h66: g.point = 16'h2592;
      7'h67: g.point = 16'h258a;
      7'h68: g.point = 16'h25db;
      7'h69: g.point = 16'h25e4;
      7'h6a: g.point = 16'h258a;
      7'h6b: g.point = 16'h2523;
      7'h6c: g.point = 16'h2597;
      7'h6d: g.point = 16'h2517;
      7'h6e: g.point = 16'h2513;
      7'h6f: g.point = 16'h2582;
      default: begin
        g.found = 1'b0;
        g.point = 16'h0000;
      end
    endcase
    return g;
  endfunction

  function automatic logic [7:0] esc_byte(input logic [1:0] pos, input logic [7:0] digit);
    logic [7:0] b;
    case (esc_pos_t'(pos))
      ESC_POS_ESC:     b = ESC_BYTE;
      ESC_POS_BRACKET: b = BRACKET_BYTE;
      ESC_POS_DIGIT:   b = digit;
      ESC_POS_END:     b = SGR_END_BYTE;
      default:         b = ESC_BYTE;
    endcase
    return b;
  endfunction

endpackage

>>> design/sc2u_if.sv
// Valid/ready channel interfaces for screencodes in and terminal bytes out.
// Depends on nothing.
`timescale 1ns / 1ps

interface sc2u_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] screen_code;

  modport source (output valid, output screen_code, input ready);
  modport sink (input valid, input screen_code, output ready);
endinterface

interface sc2u_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink (input valid, input out_byte, input last_byte, output ready);
endinterface

>>> design/sc2u_decode.sv
// Combinational decode of a held screencode into its body bytes and reverse flag.
// Depends on sc2u_pkg.
`timescale 1ns / 1ps

module sc2u_decode (
  input  sc2u_pkg::sc2u_key_t  key,
  output sc2u_pkg::sc2u_item_t item
);

  logic [6:0]       code7;
  sc2u_pkg::glyph_t glyph;

  assign code7 = key.code[6:0];
  assign glyph = sc2u_pkg::glyph_lookup(code7);

  always_comb begin
    item.rev      = key.code[7];
    item.body_len = 2'd1;
    item.body     = '0;
    if (code7 <= 7'h1f) begin
      item.body[0] = {1'b0, code7} + (key.upper ? 8'h40 : 8'h60);
    end else if (code7 < 7'h40 || (code7 <= 7'h5f && !key.upper)) begin
      item.body[0] = {1'b0, code7};
    end else if (!glyph.found) begin
      item.body[0] = sc2u_pkg::UNKNOWN_BYTE;
    end else if (glyph.point < 16'h0800) begin
      item.body_len = 2'd2;
      item.body[0]  = {3'b110, glyph.point[10:6]};
      item.body[1]  = {2'b10, glyph.point[5:0]};
    end else begin
      item.body_len = 2'd3;
      item.body[0]  = {4'b1110, glyph.point[15:12]};
      item.body[1]  = {2'b10, glyph.point[11:6]};
      item.body[2]  = {2'b10, glyph.point[5:0]};
    end
  end

endmodule

>>> design/sc2u_emit.sv
// Item register, byte index counter and output byte register of the encoder.
// Depends on sc2u_pkg and the channel interfaces in sc2u_if.sv.
`timescale 1ns / 1ps

module sc2u_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 upper_case_set,
  sc2u_code_if.sink            code_ch,
  sc2u_byte_if.source          byte_ch,
  output sc2u_pkg::sc2u_key_t  key,
  input  sc2u_pkg::sc2u_item_t item
);

  logic       item_valid;
  logic [3:0] idx;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       last_byte;

  logic       emit;
  logic       is_last;
  logic       accept;
  logic [3:0] total_len;
  logic [3:0] body_start;
  logic [3:0] rel;
  logic [3:0] sfx;
  logic [7:0] sel_byte;

  assign total_len  = {2'b00, item.body_len} + (item.rev ? sc2u_pkg::REV_EXTRA : 4'd0);
  assign body_start = item.rev ? sc2u_pkg::ESC_LEN : 4'd0;
  assign rel        = idx - body_start;
  assign sfx        = rel - {2'b00, item.body_len};
  assign is_last    = (idx == total_len - 4'd1);

  always_comb begin
    if (item.rev && idx < sc2u_pkg::ESC_LEN) begin
      sel_byte = sc2u_pkg::esc_byte(idx[1:0], sc2u_pkg::REV_ON_DIGIT);
    end else if (rel < {2'b00, item.body_len}) begin
      sel_byte = item.body[rel[1:0]];
    end else begin
      sel_byte = sc2u_pkg::esc_byte(sfx[1:0], sc2u_pkg::REV_OFF_DIGIT);
    end
  end

  // The output register frees up when its byte is taken, so the last byte of one
  // transaction and the loading of the next overlap in the same cycle.
  assign emit          = item_valid && (!out_valid || byte_ch.ready);
  assign code_ch.ready = !item_valid || (emit && is_last);
  assign accept        = code_ch.valid && code_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      idx        <= 4'd0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        item_valid <= 1'b1;
        idx        <= 4'd0;
      end else if (emit) begin
        if (is_last) begin
          item_valid <= 1'b0;
        end else begin
          idx <= idx + 4'd1;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (byte_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key.code  <= code_ch.screen_code;
      key.upper <= upper_case_set;
    end
    if (emit) begin
      out_byte  <= sel_byte;
      last_byte <= is_last;
    end
  end

  assign byte_ch.valid     = out_valid;
  assign byte_ch.out_byte  = out_byte;
  assign byte_ch.last_byte = last_byte;

`ifndef SYNTH
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    item_valid |-> idx < total_len)
    else $error("byte index past end of transaction");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !item_valid |-> code_ch.ready)
    else $error("input stalled with no transaction held");

  a_keep_until_last: assert property (@(posedge clk) disable iff (rst)
    (emit && !is_last) |=> item_valid)
    else $error("transaction dropped before its last byte");

  a_last_frees_slot: assert property (@(posedge clk) disable iff (rst)
    (emit && is_last && !code_ch.valid) |=> !item_valid)
    else $error("transaction held after its last byte");
`endif

endmodule

>>> design/screencode_to_utf8_encoder_top.sv
// The accepted screencode is held in the item register, then its bytes go out through
// the output byte register, one byte per cycle while the receiver takes them; a screencode
// gives 1 to 3 bytes, plus 8 when reverse video adds the two escape sequences (up to 11).
// A new screencode is taken in the cycle its predecessor's last byte is registered.
// Reset (synchronous): clears all valid state and sets upper_case_set to 1.
// Depends on sc2u_pkg, sc2u_if, sc2u_decode and sc2u_emit.
`timescale 1ns / 1ps

module screencode_to_utf8_encoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  sc2u_code_if.sink   code_ch,
  sc2u_byte_if.source byte_ch
);

  logic                 upper_case_set;
  sc2u_pkg::sc2u_key_t  key;
  sc2u_pkg::sc2u_item_t item;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_case_set <= 1'b1;
    end else if (cfg_we) begin
      upper_case_set <= cfg_wdata;
    end
  end

  sc2u_decode u_decode (
    .key  (key),
    .item (item)
  );

  sc2u_emit u_emit (
    .clk            (clk),
    .rst            (rst),
    .upper_case_set (upper_case_set),
    .code_ch        (code_ch),
    .byte_ch        (byte_ch),
    .key            (key),
    .item           (item)
  );

endmodule
